// ----- rtl/mme_pkg.sv -----
// Shared constants, types and helper functions of the matrix multiply engine.
package mme_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PROD_W  = 2 * DATA_WIDTH;
    localparam int ACC_W   = PROD_W + DIM_W;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

    typedef struct packed {
        logic                  busy;
        logic                  sat;
        logic [DATA_WIDTH-1:0] value;
    } t_mac_res;

    // Highest usable index for a dimension register; zero acts as one and
    // anything above the maximum acts as the maximum.
    function automatic logic [CFG_W-1:0] eff_last(input logic [CFG_W-1:0] d);
        logic [CFG_W-1:0] res;
        if (d == '0) begin
            res = '0;
        end else if (d > CFG_W'(MAX_DIM)) begin
            res = CFG_W'(MAX_DIM - 1);
        end else begin
            res = d - 1'b1;
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [CFG_W-1:0] r,
                                                    input logic [CFG_W-1:0] c);
        return ADDR_W'(r * MAX_DIM + c);
    endfunction

endpackage

// ----- rtl/mme_in_if.sv -----
// Input channel of the matrix multiply engine: command beats with load data.
interface mme_in_if;
    import mme_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             cmd;
    logic [IDX_W-1:0]             row;
    logic [IDX_W-1:0]             col;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, cmd, row, col, value, input ready);
    modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

// ----- rtl/mme_out_if.sv -----
// Output channel of the matrix multiply engine: one beat per result element.
interface mme_out_if;
    import mme_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [IDX_W-1:0]             out_row;
    logic [IDX_W-1:0]             out_col;
    logic signed [DATA_WIDTH-1:0] out_value;
    logic                         saturated;
    logic                         last;

    modport source (output valid, out_row, out_col, out_value, saturated, last,
                    input ready);
    modport sink   (input valid, out_row, out_col, out_value, saturated, last,
                    output ready);
endinterface

// ----- rtl/matrix_multiply_engine_core.sv -----
// Matrix multiply engine top level: stores A and B and emits C = A * B.
//
// Load beats (A or B element) are taken one per cycle while idle and written
// straight into the element stores; a load outside the configured dimensions
// is dropped. A compute beat then emits a_rows * b_cols result beats in
// row-major order, the final one marked with last. Each dot product runs
// through one shared multiplier fed by the single read port of each store,
// one product per cycle, then drains through the store read, product and
// accumulator registers into a registered output beat held by output stalls.
// While a product is being computed the input side is not ready.
module matrix_multiply_engine_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mme_pkg::CFG_W-1:0]       i_cfg_data,
    mme_in_if.sink                          i_in,
    mme_out_if.source                       o_out
);
    import mme_pkg::*;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_a_rows, r_a_cols, r_b_cols;
    logic [DIM_W-1:0]   r_i, n_i;
    logic [DIM_W-1:0]   r_j, n_j;
    logic [DIM_W-1:0]   r_k, n_k;
    logic               r_v1;

    logic [IDX_W-1:0]      r_out_row, n_out_row;
    logic [IDX_W-1:0]      r_out_col, n_out_col;
    logic [DATA_WIDTH-1:0] r_out_value, n_out_value;
    logic                  r_out_sat, n_out_sat;
    logic                  r_out_last, n_out_last;

    logic [CFG_W-1:0]      w_r_last, w_k_last, w_c_last;
    logic                  w_a_we, w_b_we, w_start, w_ready;
    logic [ADDR_W-1:0]     w_waddr, w_a_raddr, w_b_raddr;
    logic [DATA_WIDTH-1:0] w_a_rdata, w_b_rdata;
    t_mac_ctl              w_mac_ctl;
    t_mac_res              w_mac_res;

    assign w_r_last = eff_last(r_a_rows);
    assign w_k_last = eff_last(r_a_cols);
    assign w_c_last = eff_last(r_b_cols);

    assign w_waddr   = elem_addr(CFG_W'(i_in.row), CFG_W'(i_in.col));
    assign w_a_raddr = elem_addr(CFG_W'(r_i), CFG_W'(r_k));
    assign w_b_raddr = elem_addr(CFG_W'(r_k), CFG_W'(r_j));

    mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_a_store (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.value),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_b_store (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.value),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    assign w_mac_ctl.clear = w_start;
    assign w_mac_ctl.valid = r_v1;

    mme_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (signed'(w_a_rdata)),
        .i_b     (signed'(w_b_rdata)),
        .o_res   (w_mac_res)
    );

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_value = r_out_value;
        n_out_sat   = r_out_sat;
        n_out_last  = r_out_last;
        w_a_we      = 1'b0;
        w_b_we      = 1'b0;
        w_start     = 1'b0;
        w_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_ready = 1'b1;
                if (i_in.valid) begin
                    case (i_in.cmd)
                        CMD_LOAD_A: begin
                            w_a_we = (CFG_W'(i_in.row) <= w_r_last) &&
                                     (CFG_W'(i_in.col) <= w_k_last);
                        end
                        CMD_LOAD_B: begin
                            w_b_we = (CFG_W'(i_in.row) <= w_k_last) &&
                                     (CFG_W'(i_in.col) <= w_c_last);
                        end
                        CMD_COMPUTE: begin
                            n_i     = '0;
                            n_j     = '0;
                            n_k     = '0;
                            w_start = 1'b1;
                            n_state = S_ISSUE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ISSUE: begin
                if (CFG_W'(r_k) == w_k_last) begin
                    n_k     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = DIM_W'(r_k + 1'b1);
                end
            end
            S_DRAIN: begin
                // The sum is final once no read or product is in flight.
                if (!r_v1 && !w_mac_res.busy) begin
                    n_out_row   = IDX_W'(r_i);
                    n_out_col   = IDX_W'(r_j);
                    n_out_value = w_mac_res.value;
                    n_out_sat   = w_mac_res.sat;
                    n_out_last  = (CFG_W'(r_i) == w_r_last) &&
                                  (CFG_W'(r_j) == w_c_last);
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        if (CFG_W'(r_j) == w_c_last) begin
                            n_j = '0;
                            n_i = DIM_W'(r_i + 1'b1);
                        end else begin
                            n_j = DIM_W'(r_j + 1'b1);
                        end
                        w_start = 1'b1;
                        n_state = S_ISSUE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_a_rows <= DIM_RESET;
            r_a_cols <= DIM_RESET;
            r_b_cols <= DIM_RESET;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_v1     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_v1    <= (r_state == S_ISSUE);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_A_ROWS: r_a_rows <= i_cfg_data;
                    CFG_A_COLS: r_a_cols <= i_cfg_data;
                    CFG_B_COLS: r_b_cols <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_value <= n_out_value;
        r_out_sat   <= n_out_sat;
        r_out_last  <= n_out_last;
    end

    assign i_in.ready      = w_ready;
    assign o_out.valid     = (r_state == S_OUT);
    assign o_out.out_row   = r_out_row;
    assign o_out.out_col   = r_out_col;
    assign o_out.out_value = signed'(r_out_value);
    assign o_out.saturated = r_out_sat;
    assign o_out.last      = r_out_last;

`ifndef ASSERT_OFF
    a_out_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!r_v1 && !w_mac_res.busy))
        else $error("result beat offered while the dot product is in flight");

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while a result beat is pending");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> (r_state == S_IDLE))
        else $error("engine did not return to idle after the last beat");

    a_read_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> $past(r_state == S_ISSUE))
        else $error("store read flagged without an issue cycle");

    a_no_store_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_a_we || w_b_we) |-> (r_state == S_IDLE))
        else $error("store written while a product is being computed");
`endif
endmodule

// ----- rtl/mme_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/mme_mac.sv -----
// Shared multiply-accumulate unit with floor shift and saturation to Q8.8.
module mme_mac (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  mme_pkg::t_mac_ctl                        i_ctl,
    input  logic signed [mme_pkg::DATA_WIDTH-1:0]    i_a,
    input  logic signed [mme_pkg::DATA_WIDTH-1:0]    i_b,
    output mme_pkg::t_mac_res                        o_res
);
    import mme_pkg::*;

    localparam int SH_W = ACC_W - FRAC_BITS;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic [SH_W-1:0]          w_sh;
    logic [SH_W-DATA_WIDTH:0] w_upper;
    logic                     w_fits;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (r_pv) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.valid;
        end
        r_prod <= i_a * i_b;
        r_acc  <= n_acc;
    end

    // Dropping the fraction bits of the exact sum is a floor shift.
    assign w_sh    = r_acc[ACC_W-1:FRAC_BITS];
    assign w_upper = w_sh[SH_W-1:DATA_WIDTH-1];
    assign w_fits  = (&w_upper) | ~(|w_upper);

    always_comb begin
        o_res.busy = r_pv;
        o_res.sat  = !w_fits;
        if (w_fits) begin
            o_res.value = w_sh[DATA_WIDTH-1:0];
        end else if (w_sh[SH_W-1]) begin
            o_res.value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            o_res.value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end
endmodule

// ----- bench/tb_matrix_multiply_engine_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the matrix multiply engine core, with its own product predictor.
module tb_matrix_multiply_engine_core;
    import mme_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 120;
    localparam int IDLE_GAP     = 16;
    localparam int MAX_REPORTS  = 10;
    localparam int TIMEOUT_NS   = 20000000;

    localparam longint VAL_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;
    localparam logic [DATA_WIDTH-1:0] BITS_MAX = DATA_WIDTH'(VAL_MAX);
    localparam logic [DATA_WIDTH-1:0] BITS_MIN = DATA_WIDTH'(VAL_MIN);

    typedef struct packed {
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic [DATA_WIDTH-1:0] value;
        logic                  sat;
        logic                  last;
    } t_elem;

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} t_rx_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    mme_in_if  in_ch ();
    mme_out_if out_ch ();

    matrix_multiply_engine_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predictor copy of the registers and element stores.
    logic [CFG_W-1:0] rows_reg  = DIM_RESET;
    logic [CFG_W-1:0] inner_reg = DIM_RESET;
    logic [CFG_W-1:0] cols_reg  = DIM_RESET;
    logic signed [DATA_WIDTH-1:0] a_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] b_mem [DEPTH];
    bit a_loaded [DEPTH];
    bit b_loaded [DEPTH];
    t_elem product_q [$];

    int mismatches    = 0;
    int applied_beats = 0;
    int ignored_beats = 0;
    int compute_cnt   = 0;
    int checked_cnt   = 0;
    int sat_cnt       = 0;
    int cfg_writes    = 0;
    int burst_left    = 0;

    t_rx_mode rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       stall_left = 0;
    int       rx_cycle  = 0;

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            a_mem[i] = '0;
            b_mem[i] = '0;
        end
    end

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int eff_dim(input logic [CFG_W-1:0] d);
        if (d == '0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return int'(d);
    endfunction

    // Every element of C in row-major order; each dot product is summed
    // exactly, floored by the fraction width and clipped to the element range.
    function automatic void predict_product();
        int nr;
        int nk;
        int nc;
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] q;
        t_elem e;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                acc = '0;
                for (int k = 0; k < nk; k++) begin
                    acc += a_mem[i * MAX_DIM + k] * b_mem[k * MAX_DIM + j];
                end
                q = acc >>> FRAC_BITS;
                e.row  = IDX_W'(i);
                e.col  = IDX_W'(j);
                e.sat  = 1'b0;
                e.last = (i == nr - 1) && (j == nc - 1);
                if (q > VAL_MAX) begin
                    e.value = BITS_MAX;
                    e.sat   = 1'b1;
                end else if (q < VAL_MIN) begin
                    e.value = BITS_MIN;
                    e.sat   = 1'b1;
                end else begin
                    e.value = q[DATA_WIDTH-1:0];
                end
                product_q.push_back(e);
            end
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endfunction

    function automatic void check_field(input t_elem e, input string name,
                                        input logic [DATA_WIDTH-1:0] exp_v,
                                        input logic [DATA_WIDTH-1:0] act_v);
        if (act_v !== exp_v) begin
            note_mismatch($sformatf("C[%0d][%0d] %s expected 0x%0h, got 0x%0h",
                                    e.row, e.col, name, exp_v, act_v));
        end
    endfunction

    function automatic void take_beat();
        int nr;
        int nk;
        int nc;
        int r;
        int c;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        r  = int'(in_ch.row);
        c  = int'(in_ch.col);
        case (in_ch.cmd)
            CMD_LOAD_A: begin
                if (r < nr && c < nk) begin
                    a_mem[r * MAX_DIM + c]    = in_ch.value;
                    a_loaded[r * MAX_DIM + c] = 1'b1;
                    applied_beats++;
                end else begin
                    ignored_beats++;
                end
            end
            CMD_LOAD_B: begin
                if (r < nk && c < nc) begin
                    b_mem[r * MAX_DIM + c]    = in_ch.value;
                    b_loaded[r * MAX_DIM + c] = 1'b1;
                    applied_beats++;
                end else begin
                    ignored_beats++;
                end
            end
            CMD_COMPUTE: begin
                predict_product();
                compute_cnt++;
                applied_beats++;
            end
            default: begin
                ignored_beats++;
            end
        endcase
    endfunction

    function automatic void check_elem();
        t_elem e;
        if (product_q.size() == 0) begin
            note_mismatch($sformatf("result beat C[%0d][%0d] = 0x%0h with nothing pending",
                                    out_ch.out_row, out_ch.out_col, out_ch.out_value));
            return;
        end
        e = product_q.pop_front();
        checked_cnt++;
        if (e.sat) sat_cnt++;
        check_field(e, "out_row", DATA_WIDTH'(e.row), DATA_WIDTH'(out_ch.out_row));
        check_field(e, "out_col", DATA_WIDTH'(e.col), DATA_WIDTH'(out_ch.out_col));
        check_field(e, "out_value", e.value, out_ch.out_value);
        check_field(e, "saturated", DATA_WIDTH'(e.sat), DATA_WIDTH'(out_ch.saturated));
        check_field(e, "last", DATA_WIDTH'(e.last), DATA_WIDTH'(out_ch.last));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                cfg_writes++;
                case (i_cfg_idx)
                    CFG_A_ROWS: rows_reg  = i_cfg_data;
                    CFG_A_COLS: inner_reg = i_cfg_data;
                    CFG_B_COLS: cols_reg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) take_beat();
            if (out_ch.valid && out_ch.ready) check_elem();
        end
    end

    // The receiver switches between randomly chosen stall patterns.
    always @(posedge i_clk) begin
        rx_cycle++;
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        case (rx_mode)
            RX_OPEN:     out_ch.ready <= 1'b1;
            RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: out_ch.ready <= (rx_cycle % 5) >= 2;
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 6);
                end
            end
        endcase
    end

    function automatic logic [DATA_WIDTH-1:0] rand_value();
        logic [DATA_WIDTH-1:0] v;
        case ($urandom_range(0, 5))
            0: v = DATA_WIDTH'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: v = BITS_MIN;
                    1: v = BITS_MAX;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = DATA_WIDTH'($urandom_range(0, 2047)) - DATA_WIDTH'(1024);
        endcase
        return v;
    endfunction

    // Drives one beat and returns at the edge where it is taken. The sender
    // runs in bursts with random gaps between them.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col,
                             input logic [DATA_WIDTH-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= cmd;
        in_ch.row   <= row;
        in_ch.col   <= col;
        in_ch.value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (product_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                            input logic [CFG_W-1:0] cols);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_A_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_A_COLS;
        i_cfg_data <= inner;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_B_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic compute();
        send_beat(CMD_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), rand_value());
    endtask

    task automatic load_matrices();
        int nr;
        int nk;
        int nc;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        for (int r = 0; r < nr; r++)
            for (int k = 0; k < nk; k++)
                send_beat(CMD_LOAD_A, IDX_W'(r), IDX_W'(k), rand_value());
        for (int c = 0; c < nc; c++)
            for (int k = 0; k < nk; k++)
                send_beat(CMD_LOAD_B, IDX_W'(k), IDX_W'(c), rand_value());
    endtask

    // Loads every entry the next product reads that has never been written.
    task automatic fill_missing();
        int nr;
        int nk;
        int nc;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        for (int r = 0; r < nr; r++)
            for (int k = 0; k < nk; k++)
                if (!a_loaded[r * MAX_DIM + k])
                    send_beat(CMD_LOAD_A, IDX_W'(r), IDX_W'(k), rand_value());
        for (int k = 0; k < nk; k++)
            for (int c = 0; c < nc; c++)
                if (!b_loaded[k * MAX_DIM + c])
                    send_beat(CMD_LOAD_B, IDX_W'(k), IDX_W'(c), rand_value());
    endtask

    task automatic send_noise(input int n, input bit mostly_valid);
        int sel;
        int nr;
        int nk;
        int nc;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        repeat (n) begin
            sel = $urandom_range(0, 3);
            if (sel == 3) begin
                send_beat(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), rand_value());
            end else if (mostly_valid && sel == 1) begin
                send_beat(CMD_LOAD_A, IDX_W'($urandom_range(0, nr - 1)),
                          IDX_W'($urandom_range(0, nk - 1)), rand_value());
            end else if (mostly_valid && sel == 2) begin
                send_beat(CMD_LOAD_B, IDX_W'($urandom_range(0, nk - 1)),
                          IDX_W'($urandom_range(0, nc - 1)), rand_value());
            end else begin
                send_beat(sel[0] ? CMD_LOAD_A : CMD_LOAD_B, IDX_W'($urandom),
                          IDX_W'($urandom), rand_value());
            end
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        if ($urandom_range(0, 9) < 7) return CFG_W'($urandom_range(1, 4));
        return CFG_W'($urandom_range(0, 15));
    endfunction

    // Single-element products: saturation both ways and floor rounding.
    task automatic test_unit_extremes();
        set_dims(4'd1, 4'd1, 4'd1);
        send_beat(CMD_LOAD_A, '0, '0, BITS_MIN);
        send_beat(CMD_LOAD_B, '0, '0, BITS_MIN);
        compute();
        send_beat(CMD_LOAD_B, '0, '0, BITS_MAX);
        compute();
        send_beat(CMD_LOAD_A, '0, '0, BITS_MAX);
        compute();
        send_beat(CMD_LOAD_A, '0, '0, DATA_WIDTH'(1));
        send_beat(CMD_LOAD_B, '0, '0, '1);
        compute();
        send_beat(CMD_LOAD_A, '0, '0, DATA_WIDTH'(-3));
        send_beat(CMD_LOAD_B, '0, '0, DATA_WIDTH'(100));
        compute();
        send_beat(CMD_LOAD_A, '0, '0, DATA_WIDTH'(256));
        send_beat(CMD_LOAD_B, '0, '0, DATA_WIDTH'(384));
        compute();
    endtask

    // Out-of-range loads and the unused command must leave the stores alone.
    task automatic test_ignored_beats();
        send_beat(CMD_LOAD_A, 3'd1, 3'd0, BITS_MAX);
        send_beat(CMD_LOAD_A, 3'd0, 3'd7, BITS_MIN);
        send_beat(CMD_LOAD_B, 3'd7, 3'd7, BITS_MAX);
        send_beat(CMD_LOAD_B, 3'd0, 3'd1, BITS_MIN);
        send_beat(CMD_UNUSED, 3'd0, 3'd0, BITS_MAX);
        send_beat(CMD_COMPUTE, 3'd7, 3'd7, '1);
    endtask

    task automatic test_zero_dims();
        set_dims('0, '0, '0);
        compute();
    endtask

    task automatic test_largest();
        set_dims('1, '1, '1);
        load_matrices();
        compute();
        set_dims(CFG_W'(MAX_DIM), 4'd1, CFG_W'(MAX_DIM));
        send_noise(6, 1'b1);
        fill_missing();
        compute();
    endtask

    task automatic test_matrix_vector();
        repeat (3) begin
            set_dims(CFG_W'($urandom_range(1, MAX_DIM)), CFG_W'($urandom_range(1, MAX_DIM)),
                     4'd1);
            load_matrices();
            compute();
        end
    endtask

    task automatic test_random_phases();
        int start;
        int pick;
        start = applied_beats;
        while (applied_beats - start < RANDOM_BEATS) begin
            if ($urandom_range(0, 3) != 0) set_dims(pick_dim(), pick_dim(), pick_dim());
            pick = $urandom_range(0, 9);
            if (pick < 6) load_matrices();
            else send_noise($urandom_range(1, 12), pick < 8);
            fill_missing();
            compute();
            if ($urandom_range(0, 4) == 0) compute();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.cmd    = '0;
        in_ch.row    = '0;
        in_ch.col    = '0;
        in_ch.value  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unit_extremes();
        test_ignored_beats();
        test_zero_dims();
        test_largest();
        test_matrix_vector();
        test_random_phases();
        wait_idle();

        $display("Ran %0d products (%0d elements checked, %0d clipped) from %0d applied beats.",
                 compute_cnt, checked_cnt, sat_cnt, applied_beats);
        $display("Dropped %0d ignored beats, wrote %0d registers, saw %0d mismatches.",
                 ignored_beats, cfg_writes, mismatches);
        if (mismatches == 0 && product_q.size() == 0) begin
            $display("matrix_multiply_engine_core verification clean");
        end else begin
            $display("matrix_multiply_engine_core verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d elements still pending.", product_q.size());
        $display("matrix_multiply_engine_core verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mme_pkg.sv
rtl/mme_in_if.sv
rtl/mme_out_if.sv
rtl/mme_ram.sv
rtl/mme_mac.sv
rtl/matrix_multiply_engine_core.sv
bench/tb_matrix_multiply_engine_core.sv
